FILE: hw/rtl/psv_pkg.sv
// ----------------------------------------------------------------------------
// psv_pkg
// Shared types and constants for the plucked string voice: datapath command
// codes, controller states, control and status bundles, fixed coefficients.
// ----------------------------------------------------------------------------
package psv_pkg;

  // multiplier operand, product and accumulator widths
  localparam int MUL_W = 20;
  localparam int PRD_W = 2 * MUL_W;
  localparam int ACC_W = 2 * MUL_W + 1;
  // divider divisor width
  localparam int DEN_W = 20;

  // configuration register indexes
  localparam logic [2:0] CFG_DAMPING    = 3'd0;
  localparam logic [2:0] CFG_DECAY      = 3'd1;
  localparam logic [2:0] CFG_STRETCH    = 3'd2;
  localparam logic [2:0] CFG_BRIGHTNESS = 3'd3;
  localparam logic [2:0] CFG_EXC_TYPE   = 3'd4;

  // exciter kinds
  localparam logic [1:0] EXC_NOISE  = 2'd0;
  localparam logic [1:0] EXC_BRIGHT = 2'd1;
  localparam logic [1:0] EXC_SAW    = 2'd2;
  localparam logic [1:0] EXC_SINE   = 2'd3;

  // coefficients
  localparam logic [31:0] NOISE_SEED = 32'd54321;
  localparam logic [16:0] LP_BASE    = 17'd32768;
  localparam logic [16:0] LP_SPAN    = 17'd29491;
  localparam logic [16:0] G_BASE     = 17'd58982;
  localparam logic [16:0] G_SPAN     = 17'd6488;
  localparam logic [16:0] MIX_LP     = 17'd19661;
  localparam logic [16:0] UNITY      = 17'd65536;
  localparam logic [16:0] SIN_K3     = 17'd2320;
  localparam logic [16:0] SIN_K2     = 17'd21024;
  localparam logic [16:0] SIN_K1     = 17'd51472;
  localparam logic [16:0] SAW_OFS    = 17'd32768;

  // datapath operations
  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_NOTE_OUT,
    OP_DRAW_S, OP_DRAW_T, OP_DRAW_AVG, OP_BRIGHT,
    OP_SAW_MOD, OP_SAW_DIV, OP_SAW_S,
    OP_SIN_DIV, OP_SIN_X, OP_SIN_X2, OP_SIN_Y1, OP_SIN_Y3, OP_SIN_Y5, OP_ZERO_S,
    OP_MIX_A, OP_MIX_B, OP_MIX_C,
    OP_ENV_DIV, OP_ENV_S, OP_ENV_G,
    OP_RD0, OP_RD1, OP_DLY0, OP_DLY1,
    OP_LPC, OP_LP0, OP_LP1, OP_AP0, OP_AP1, OP_FB0, OP_FB1, OP_G, OP_WB
  } dp_op_t;

  // controller states
  typedef enum logic [5:0] {
    S_IDLE, S_NOTE_OUT, S_TICK,
    S_DRAW_S, S_DRAW_T, S_DRAW_AVG, S_BRIGHT,
    S_SAW_MOD, S_SAW_MOD_W, S_SAW_DIV, S_SAW_DIV_W, S_SAW_S,
    S_SIN_DIV, S_SIN_DIV_W, S_SIN_X, S_SIN_X2, S_SIN_Y1, S_SIN_Y3, S_SIN_Y5, S_ZERO_S,
    S_MIX_A, S_MIX_B, S_MIX_C,
    S_ENV_DIV, S_ENV_DIV_W, S_ENV_S, S_ENV_G,
    S_RD0, S_RD1, S_DLY0, S_DLY1,
    S_LPC, S_LP0, S_LP1, S_AP0, S_AP1, S_FB0, S_FB1, S_G, S_WB
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic       inj_ok;
    logic [1:0] exc_type;
    logic       period_zero;
    logic       div_busy;
    logic       out_hold;
  } status_t;

  // unsigned value into a signed multiplier operand
  function automatic logic signed [MUL_W-1:0] uop(input logic [16:0] v);
    return signed'(MUL_W'(v));
  endfunction

endpackage

FILE: hw/rtl/psv_div.sv
// ----------------------------------------------------------------------------
// psv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psv_div #(
  parameter int NW = 36
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [NW-1:0]            num,
  input  logic [psv_pkg::DEN_W-1:0] den,
  output logic                     busy,
  output logic [NW-1:0]            quo,
  output logic [psv_pkg::DEN_W-1:0] rem
);
  import psv_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [NW-1:0]     quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W+1:0]  diff;
  logic              ge;

  // shift in next dividend bit and trial subtract
  always_comb begin
    rem_sh = {rem_r, quo_r[NW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = ~diff[DEN_W+1];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

FILE: hw/rtl/psv_ctrl.sv
// ----------------------------------------------------------------------------
// psv_ctrl
// Sequencer for the voice: walks one item through excitation, delay read,
// filters and write-back, issuing at most one datapath operation per state.
// ----------------------------------------------------------------------------
module psv_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_stall,
  input  psv_pkg::status_t sts,
  output psv_pkg::cmd_t    cmd
);
  import psv_pkg::*;

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = in_op ? S_NOTE_OUT : S_TICK;
        end
      end
      S_NOTE_OUT: begin
        if (!sts.out_hold) begin
          cmd.op    = OP_NOTE_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (!sts.inj_ok) begin
          state_nxt = S_RD0;
        end else begin
          case (sts.exc_type)
            EXC_NOISE:  state_nxt = S_DRAW_S;
            EXC_BRIGHT: state_nxt = S_DRAW_T;
            EXC_SAW:    state_nxt = S_SAW_MOD;
            EXC_SINE:   state_nxt = sts.period_zero ? S_ZERO_S : S_SIN_DIV;
            default:    state_nxt = S_RD0;
          endcase
        end
      end
      // noise kinds
      S_DRAW_S:   begin cmd.op = OP_DRAW_S;   state_nxt = S_MIX_A;    end
      S_DRAW_T:   begin cmd.op = OP_DRAW_T;   state_nxt = S_DRAW_AVG; end
      S_DRAW_AVG: begin cmd.op = OP_DRAW_AVG; state_nxt = S_BRIGHT;   end
      S_BRIGHT:   begin cmd.op = OP_BRIGHT;   state_nxt = S_MIX_A;    end
      // saw
      S_SAW_MOD:  begin cmd.op = OP_SAW_MOD;  state_nxt = S_SAW_MOD_W; end
      S_SAW_MOD_W: begin
        if (!sts.div_busy) state_nxt = S_SAW_DIV;
      end
      S_SAW_DIV:  begin cmd.op = OP_SAW_DIV;  state_nxt = S_SAW_DIV_W; end
      S_SAW_DIV_W: begin
        if (!sts.div_busy) state_nxt = S_SAW_S;
      end
      S_SAW_S:    begin cmd.op = OP_SAW_S;    state_nxt = S_MIX_A; end
      // sine burst
      S_SIN_DIV:  begin cmd.op = OP_SIN_DIV;  state_nxt = S_SIN_DIV_W; end
      S_SIN_DIV_W: begin
        if (!sts.div_busy) state_nxt = S_SIN_X;
      end
      S_SIN_X:    begin cmd.op = OP_SIN_X;    state_nxt = S_SIN_X2; end
      S_SIN_X2:   begin cmd.op = OP_SIN_X2;   state_nxt = S_SIN_Y1; end
      S_SIN_Y1:   begin cmd.op = OP_SIN_Y1;   state_nxt = S_SIN_Y3; end
      S_SIN_Y3:   begin cmd.op = OP_SIN_Y3;   state_nxt = S_SIN_Y5; end
      S_SIN_Y5:   begin cmd.op = OP_SIN_Y5;   state_nxt = S_MIX_A;  end
      S_ZERO_S:   begin cmd.op = OP_ZERO_S;   state_nxt = S_MIX_A;  end
      // brightness mix and envelope
      S_MIX_A:    begin cmd.op = OP_MIX_A;    state_nxt = S_MIX_B;  end
      S_MIX_B:    begin cmd.op = OP_MIX_B;    state_nxt = S_MIX_C;  end
      S_MIX_C:    begin cmd.op = OP_MIX_C;    state_nxt = S_ENV_DIV; end
      S_ENV_DIV:  begin cmd.op = OP_ENV_DIV;  state_nxt = S_ENV_DIV_W; end
      S_ENV_DIV_W: begin
        if (!sts.div_busy) state_nxt = S_ENV_S;
      end
      S_ENV_S:    begin cmd.op = OP_ENV_S;    state_nxt = S_ENV_G; end
      S_ENV_G:    begin cmd.op = OP_ENV_G;    state_nxt = S_RD0;   end
      // string loop
      S_RD0:      begin cmd.op = OP_RD0;      state_nxt = S_RD1;  end
      S_RD1:      begin cmd.op = OP_RD1;      state_nxt = S_DLY0; end
      S_DLY0:     begin cmd.op = OP_DLY0;     state_nxt = S_DLY1; end
      S_DLY1:     begin cmd.op = OP_DLY1;     state_nxt = S_LPC;  end
      S_LPC:      begin cmd.op = OP_LPC;      state_nxt = S_LP0;  end
      S_LP0:      begin cmd.op = OP_LP0;      state_nxt = S_LP1;  end
      S_LP1:      begin cmd.op = OP_LP1;      state_nxt = S_AP0;  end
      S_AP0:      begin cmd.op = OP_AP0;      state_nxt = S_AP1;  end
      S_AP1:      begin cmd.op = OP_AP1;      state_nxt = S_FB0;  end
      S_FB0:      begin cmd.op = OP_FB0;      state_nxt = S_FB1;  end
      S_FB1:      begin cmd.op = OP_FB1;      state_nxt = S_G;    end
      S_G:        begin cmd.op = OP_G;        state_nxt = S_WB;   end
      S_WB: begin
        if (!sts.out_hold) begin
          cmd.op    = OP_WB;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/psv_dpath.sv
// ----------------------------------------------------------------------------
// psv_dpath
// Voice datapath: config registers, voice state, shared multiply-accumulate,
// shared divider, delay line memory with fill count, output register.
// ----------------------------------------------------------------------------
module psv_dpath #(
  parameter int DELAY_DEPTH      = 4096,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  psv_pkg::cmd_t      cmd,
  output psv_pkg::status_t   sts,
  input  logic               in_op,
  input  logic [19:0]        in_delay_length,
  input  logic [15:0]        in_velocity_gain,
  input  logic [15:0]        in_excite_length,
  input  logic               cfg_wr,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_string_sample,
  output logic               out_exciting
);
  import psv_pkg::*;

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int SB  = $clog2(SINE_TABLE_DEPTH);
  localparam int DNW = (24 + SB > 36) ? 24 + SB : 36;
  localparam int RW  = AW + 8;

  // configuration
  logic [15:0] damp_r, decay_r, stretch_r, bright_r;
  logic [1:0]  exc_type_r;
  // voice state
  logic [19:0]              period_r;
  logic [15:0]              gain_r, blen_r, bpos_r;
  logic [31:0]              noise_r;
  logic [AW-1:0]            wi_r, i1_r;
  logic [AW:0]              fill_r;
  logic signed [15:0]       lp_r, ap_r, dly_r, d0_r;
  logic                     inj_r, sg_r, rv_r;
  // scratch
  logic signed [MUL_W-1:0]  s_r, t_r, x_r, exc_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [16:0]              lpc_r, g_r;
  logic [7:0]               fr_r;
  // output stage
  logic                     out_valid_r, out_exciting_r;
  logic signed [15:0]       out_sample_r;
  // memory
  logic signed [15:0]       mem [DELAY_DEPTH];
  logic signed [15:0]       mem_q_r;
  logic                     rd_en, wr_en;
  logic [AW-1:0]            rd_addr;
  logic signed [15:0]       wr_data;

  // divider
  logic                     div_start, div_busy;
  logic [DNW-1:0]           div_num, div_quo;
  logic [DEN_W-1:0]         div_den, div_rem;

  // combinational helpers
  logic [31:0]              nw1, nw2, nw3;
  logic signed [MUL_W-1:0]  draw;
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [PRD_W-1:0]  prod, prod_sh16, prod_sh15, wb_sum;
  logic signed [ACC_W-1:0]  sum, sum_sh16, sum_sh8;
  logic [19:0]              saw_len, per_int, ten_pos;
  logic                     env_rise;
  logic [RW-1:0]            rp;
  logic [15:0]              sin_t;
  logic [14:0]              sin_u;
  logic [15:0]              sin_x;
  logic signed [PRD_W-1:0]  sin_y;
  logic signed [15:0]       d1;
  logic [16:0]              apc;

  // xorshift noise step
  always_comb begin
    nw1  = noise_r ^ (noise_r << 13);
    nw2  = nw1 ^ (nw1 >> 17);
    nw3  = nw2 ^ (nw2 << 5);
    draw = MUL_W'(signed'(nw3[31:16]));
  end

  // saw length, envelope branch, read pointer, sine phase
  always_comb begin
    per_int  = {8'h00, period_r[19:8]};
    saw_len  = (per_int > 20'(DELAY_DEPTH - 1)) ? 20'(DELAY_DEPTH - 1) : per_int;
    if (saw_len == 20'd0) saw_len = 20'd1;
    ten_pos  = {1'b0, bpos_r, 3'b000} + {3'b000, bpos_r, 1'b0};
    env_rise = ten_pos < {4'h0, blen_r};
    rp       = {wi_r, 8'h00} - RW'(period_r);
    sin_t    = 16'(div_quo[SB-1:0]) << (16 - SB);
    sin_u    = {1'b0, sin_t[13:0]};
    if (sin_t[14]) sin_u = 15'd16384 - sin_u;
    sin_x    = {sin_u, 1'b0};
    apc      = {2'b00, stretch_r[15:1]};
    d1       = rv_r ? mem_q_r : 16'sd0;
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_SAW_MOD: begin
        div_start = 1'b1;
        div_num   = DNW'(bpos_r);
        div_den   = saw_len;
      end
      OP_SAW_DIV: begin
        div_start = 1'b1;
        div_num   = DNW'({div_rem[15:0], 16'h0000});
        div_den   = saw_len;
      end
      OP_SIN_DIV: begin
        div_start = 1'b1;
        div_num   = DNW'(bpos_r) << (8 + SB);
        div_den   = period_r;
      end
      OP_ENV_DIV: begin
        div_start = 1'b1;
        if (env_rise) begin
          div_num = (DNW'(bpos_r) << 19) + (DNW'(bpos_r) << 17);
          div_den = {4'h0, blen_r};
        end else begin
          div_num = (DNW'(blen_r - bpos_r) << 19) + (DNW'(blen_r - bpos_r) << 17);
          div_den = {1'b0, blen_r, 3'b000} + {4'h0, blen_r};
        end
      end
      default: ;
    endcase
  end

  psv_div #(.NW(DNW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_BRIGHT: begin ma = s_r;                 mb = uop(UNITY + 17'(bright_r)); end
      OP_SIN_X2: begin ma = x_r;                 mb = x_r;                        end
      OP_SIN_Y1: begin ma = uop(SIN_K3);         mb = t_r;                        end
      OP_SIN_Y3: begin ma = s_r;                 mb = t_r;                        end
      OP_SIN_Y5: begin ma = s_r;                 mb = x_r;                        end
      OP_MIX_A:  begin ma = MUL_W'(lp_r);        mb = uop(UNITY - 17'(bright_r)); end
      OP_MIX_B:  begin ma = t_r;                 mb = uop(MIX_LP);                end
      OP_MIX_C:  begin ma = s_r;                 mb = uop(17'(bright_r));         end
      OP_ENV_S:  begin ma = s_r;                 mb = uop(div_quo[16:0]);         end
      OP_ENV_G:  begin ma = s_r;                 mb = uop(17'(gain_r));           end
      OP_DLY0:   begin ma = MUL_W'(d0_r);        mb = uop(17'd256 - 17'(fr_r));   end
      OP_DLY1:   begin ma = MUL_W'(d1);          mb = uop(17'(fr_r));             end
      OP_LPC:    begin ma = uop(LP_SPAN);        mb = uop(17'(damp_r));           end
      OP_LP0:    begin ma = MUL_W'(lp_r);        mb = uop(lpc_r);                 end
      OP_LP1:    begin ma = MUL_W'(dly_r);       mb = uop(UNITY - lpc_r);         end
      OP_AP0:    begin ma = uop(apc);            mb = MUL_W'(lp_r);               end
      OP_AP1:    begin ma = MUL_W'(ap_r);        mb = uop(UNITY - apc);           end
      OP_FB0:    begin ma = MUL_W'(lp_r);        mb = uop(UNITY - 17'(stretch_r)); end
      OP_FB1:    begin ma = t_r;                 mb = uop(17'(stretch_r));        end
      OP_G:      begin ma = uop(G_SPAN);         mb = uop(17'(decay_r));          end
      OP_WB:     begin ma = s_r;                 mb = uop(g_r);                   end
      default: ;
    endcase
  end

  // multiply, accumulate and the usual rescales
  always_comb begin
    prod      = ma * mb;
    prod_sh16 = prod >>> 16;
    prod_sh15 = prod >>> 15;
    sum       = acc_r + ACC_W'(prod);
    sum_sh16  = sum >>> 16;
    sum_sh8   = sum >>> 8;
    sin_y     = (prod_sh15 > PRD_W'(32767)) ? PRD_W'(32767) : prod_sh15;
    wb_sum    = prod_sh16 + PRD_W'(exc_r);
    if (wb_sum > PRD_W'(32767)) begin
      wr_data = 16'sh7fff;
    end else if (wb_sum < -PRD_W'(32768)) begin
      wr_data = 16'sh8000;
    end else begin
      wr_data = wb_sum[15:0];
    end
  end

  // memory access
  always_comb begin
    rd_en   = (cmd.op == OP_RD0) || (cmd.op == OP_RD1);
    rd_addr = (cmd.op == OP_RD0) ? rp[RW-1:8] : i1_r;
    wr_en   = (cmd.op == OP_WB);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wi_r] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r     <= 16'd32768;
      decay_r    <= 16'd32768;
      stretch_r  <= 16'd0;
      bright_r   <= 16'd32768;
      exc_type_r <= EXC_NOISE;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_DAMPING:    damp_r     <= cfg_data;
        CFG_DECAY:      decay_r    <= cfg_data;
        CFG_STRETCH:    stretch_r  <= cfg_data;
        CFG_BRIGHTNESS: bright_r   <= cfg_data;
        CFG_EXC_TYPE:   exc_type_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      gain_r   <= '0;
      blen_r   <= '0;
      bpos_r   <= '0;
      noise_r  <= NOISE_SEED;
      wi_r     <= '0;
      fill_r   <= '0;
      lp_r     <= '0;
      ap_r     <= '0;
      inj_r    <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          inj_r <= 1'b0;
          if (in_op) begin
            period_r <= in_delay_length;
            gain_r   <= in_velocity_gain;
            blen_r   <= (in_excite_length == 16'd0) ? 16'd1 : in_excite_length;
            bpos_r   <= '0;
            wi_r     <= '0;
            fill_r   <= '0;
            lp_r     <= '0;
            ap_r     <= '0;
          end
        end
        OP_DRAW_S, OP_DRAW_T, OP_DRAW_AVG: noise_r <= nw3;
        OP_ENV_G: begin
          bpos_r <= bpos_r + 16'd1;
          inj_r  <= 1'b1;
        end
        OP_LP1:  lp_r <= sum_sh16[15:0];
        OP_FB1:  ap_r <= lp_r;
        OP_WB: begin
          wi_r <= wi_r + 1'b1;
          if (fill_r != (AW+1)'(DELAY_DEPTH)) fill_r <= fill_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // scratch registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:     exc_r <= '0;
      OP_DRAW_S:   s_r   <= draw;
      OP_DRAW_T:   t_r   <= draw;
      OP_DRAW_AVG: s_r   <= (t_r + draw) >>> 1;
      OP_BRIGHT:   s_r   <= prod_sh16[MUL_W-1:0];
      OP_SAW_S:    s_r   <= uop(div_quo[16:0]) - uop(SAW_OFS);
      OP_SIN_X: begin
        x_r  <= uop(17'(sin_x));
        sg_r <= sin_t[15];
      end
      OP_SIN_X2:   t_r   <= prod_sh15[MUL_W-1:0];
      OP_SIN_Y1:   s_r   <= uop(SIN_K2) - prod_sh15[MUL_W-1:0];
      OP_SIN_Y3:   s_r   <= uop(SIN_K1) - prod_sh15[MUL_W-1:0];
      OP_SIN_Y5:   s_r   <= sg_r ? -sin_y[MUL_W-1:0] : sin_y[MUL_W-1:0];
      OP_ZERO_S:   s_r   <= '0;
      OP_MIX_A:    t_r   <= prod_sh16[MUL_W-1:0];
      OP_MIX_B:    t_r   <= prod_sh16[MUL_W-1:0];
      OP_MIX_C:    s_r   <= prod_sh16[MUL_W-1:0] + t_r;
      OP_ENV_S:    s_r   <= prod_sh16[MUL_W-1:0];
      OP_ENV_G:    exc_r <= prod_sh16[MUL_W-1:0];
      OP_RD0: begin
        fr_r <= rp[7:0];
        i1_r <= rp[RW-1:8] + 1'b1;
        rv_r <= {1'b0, rp[RW-1:8]} < fill_r;
      end
      OP_RD1: begin
        d0_r <= rv_r ? mem_q_r : 16'sd0;
        rv_r <= {1'b0, i1_r} < fill_r;
      end
      OP_DLY0:     acc_r <= ACC_W'(prod);
      OP_DLY1:     dly_r <= sum_sh8[15:0];
      OP_LPC:      lpc_r <= LP_BASE + prod_sh16[16:0];
      OP_LP0:      acc_r <= ACC_W'(prod);
      OP_AP0:      acc_r <= ACC_W'(prod);
      OP_AP1:      t_r   <= sum_sh16[MUL_W-1:0];
      OP_FB0:      acc_r <= ACC_W'(prod);
      OP_FB1:      s_r   <= sum_sh16[MUL_W-1:0];
      OP_G:        g_r   <= G_BASE + prod_sh16[16:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.op == OP_WB) || (cmd.op == OP_NOTE_OUT)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WB) begin
      out_sample_r   <= dly_r;
      out_exciting_r <= inj_r;
    end else if (cmd.op == OP_NOTE_OUT) begin
      out_sample_r   <= '0;
      out_exciting_r <= 1'b0;
    end
  end

  // status back to the controller
  always_comb begin
    sts.inj_ok      = bpos_r < blen_r;
    sts.exc_type    = exc_type_r;
    sts.period_zero = (period_r == 20'd0);
    sts.div_busy    = div_busy;
    sts.out_hold    = out_valid_r & out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_string_sample = out_sample_r;
  assign out_exciting      = out_exciting_r;

endmodule

FILE: hw/rtl/plucked_string_voice_unit.sv
// ----------------------------------------------------------------------------
// plucked_string_voice_unit
// One plucked string voice: note-start and tick words in, one sample word out.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  op, delay_length, velocity_gain,
//                                          excite_length
//   out_     output     out_valid/stall    string_sample, exciting
//   cfg_     input      cfg_valid/ready    cfg_index, cfg_data
//
// A tick with excitation waits on the shared one-bit-per-cycle divider: one
// division for noise kinds, two for sine (one if the period is zero) and
// three for saw; a tick without excitation and a note start use none.
// The delay line needs no clearing pass: a fill count marks written entries.
// The output register holds a word under out_stall while the next input word
// is taken; that word finishes once the register frees. rst_n is synchronous.
// ----------------------------------------------------------------------------
module plucked_string_voice_unit #(
  parameter int DELAY_DEPTH      = 4096,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [19:0]        in_delay_length,
  input  logic [15:0]        in_velocity_gain,
  input  logic [15:0]        in_excite_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_string_sample,
  output logic               out_exciting,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import psv_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // configuration registers take a write on any cycle
  assign cfg_ready = 1'b1;

  psv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psv_dpath #(
    .DELAY_DEPTH      (DELAY_DEPTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_delay_length   (in_delay_length),
    .in_velocity_gain  (in_velocity_gain),
    .in_excite_length  (in_excite_length),
    .cfg_wr            (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_string_sample (out_string_sample),
    .out_exciting      (out_exciting)
  );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plucked string voice testbench
// Drives note-start and tick words into the voice, predicts every sample word
// with a bit-exact model of the string loop, and compares each output word in
// order. Runs several register settings and sender/receiver idling phases.
// ----------------------------------------------------------------------------
module testbench;
  import psv_pkg::*;

  localparam int DEPTH = 4096;
  localparam int SDEPTH = 256;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        op;
    logic [19:0] dlen;
    logic [15:0] vgain;
    logic [15:0] elen;
  } voice_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               exciting;
  } sample_word_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_op;
  logic [19:0] in_delay_length;
  logic [15:0] in_velocity_gain, in_excite_length;
  logic out_valid, out_stall, out_exciting;
  logic signed [15:0] out_string_sample;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  plucked_string_voice_unit DUT (.*);

  // voice model state
  logic [15:0] m_damping, m_decay, m_stretch, m_bright;
  logic [1:0]  m_exc;
  logic signed [15:0] m_line [DEPTH];
  int unsigned m_widx, m_period, m_bpos, m_blen, m_vgain;
  longint m_lp, m_ap;
  logic [31:0] m_noise;

  voice_word_t  pending_words[$];
  sample_word_t expected_samples[$];
  int send_idle_pct, stall_pct, mismatches, idle_cycles, checked;
  bit stim_done;

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint draw_noise();
    m_noise = m_noise ^ (m_noise << 13);
    m_noise = m_noise ^ (m_noise >> 17);
    m_noise = m_noise ^ (m_noise << 5);
    return longint'($signed(m_noise[31:16]));
  endfunction

  function automatic longint sine_value(longint unsigned idx);
    longint unsigned t, q, u, x, x2, y;
    t = (idx * 65536) / SDEPTH;
    q = (t >> 14) & 3;
    u = t & 'h3FFF;
    if (q & 1) u = 16384 - u;
    x = u << 1;
    x2 = (x * x) >> 15;
    y = (2320 * x2) >> 15;
    y = 21024 - y;
    y = (y * x2) >> 15;
    y = 51472 - y;
    y = (y * x) >> 15;
    if (y > 32767) y = 32767;
    return (q & 2) ? -longint'(y) : longint'(y);
  endfunction

  function automatic longint burst_sample();
    longint s, e, a, b, lpmix;
    longint unsigned pos, len, l;
    pos = m_bpos;
    len = m_blen;
    s = 0;
    case (m_exc)
      EXC_NOISE: s = draw_noise();
      EXC_BRIGHT: begin
        a = draw_noise();
        b = draw_noise();
        s = floor_shift(a + b, 1);
        s = floor_shift(s * (65536 + longint'(m_bright)), 16);
      end
      EXC_SAW: begin
        l = m_period >> 8;
        if (l > DEPTH - 1) l = DEPTH - 1;
        if (l == 0) l = 1;
        s = longint'(((pos % l) * 65536) / l) - 32768;
      end
      default: begin
        if (m_period != 0) s = sine_value(((pos * 256 * SDEPTH) / m_period) % SDEPTH);
      end
    endcase
    lpmix = floor_shift(m_lp * (65536 - longint'(m_bright)), 16);
    s = floor_shift(s * longint'(m_bright), 16) + floor_shift(lpmix * 19661, 16);
    if (10 * pos < len) e = longint'((655360 * pos) / len);
    else e = longint'((655360 * (len - pos)) / (9 * len));
    s = floor_shift(s * e, 16);
    return floor_shift(s * longint'(m_vgain), 16);
  endfunction

  function automatic sample_word_t voice_step(voice_word_t w);
    sample_word_t r;
    longint exc, dly, lpc, apc, apin, apout, fb, g;
    longint unsigned rp, span;
    int unsigned i0, i1, fr;
    span = DEPTH * 256;
    r = '0;
    exc = 0;
    if (w.op) begin
      m_period = w.dlen;
      m_vgain = w.vgain;
      m_blen = (w.elen == 0) ? 1 : w.elen;
      m_bpos = 0;
      foreach (m_line[i]) m_line[i] = '0;
      m_widx = 0;
      m_lp = 0;
      m_ap = 0;
      return r;
    end
    if (m_bpos < m_blen) begin
      exc = burst_sample();
      m_bpos++;
      r.exciting = 1'b1;
    end
    rp = (longint'(m_widx) * 256 + span - (m_period % span)) % span;
    i0 = rp >> 8;
    i1 = (i0 + 1) % DEPTH;
    fr = rp & 255;
    dly = floor_shift(longint'(m_line[i0]) * (256 - fr) + longint'(m_line[i1]) * fr, 8);
    lpc = 32768 + ((29491 * longint'(m_damping)) >> 16);
    m_lp = floor_shift(m_lp * lpc + dly * (65536 - lpc), 16);
    apc = m_stretch >> 1;
    apin = m_lp;
    apout = floor_shift(apc * apin + m_ap * (65536 - apc), 16);
    fb = floor_shift(apin * (65536 - longint'(m_stretch)) + apout * longint'(m_stretch), 16);
    m_ap = apin;
    g = 58982 + ((6488 * longint'(m_decay)) >> 16);
    m_line[m_widx] = 16'(clip16(floor_shift(fb * g, 16) + exc));
    m_widx = (m_widx + 1) % DEPTH;
    r.sample = 16'(dly);
    return r;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input driver: predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_samples.push_back(voice_step({in_op, in_delay_length,
                                               in_velocity_gain, in_excite_length}));
        void'(pending_words.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (pending_words.size() != 0 &&
                   !($urandom_range(99) < send_idle_pct)) begin
        in_valid <= 1'b1;
        {in_op, in_delay_length, in_velocity_gain, in_excite_length} <= pending_words[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output word %0d", out_string_sample);
        end else begin
          sample_word_t x;
          x = expected_samples.pop_front();
          checked++;
          if (x.sample !== out_string_sample || x.exciting !== out_exciting) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected sample %0d exciting %0d, got %0d %0d",
                       checked, x.sample, x.exciting, out_string_sample, out_exciting);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress, %0d words outstanding", expected_samples.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // one register write, then cfg_valid is deasserted before the task returns
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DAMPING:    m_damping = val;
      CFG_DECAY:      m_decay = val;
      CFG_STRETCH:    m_stretch = val;
      CFG_BRIGHTNESS: m_bright = val;
      CFG_EXC_TYPE:   m_exc = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_words();
    while (pending_words.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic add_note(input logic [19:0] dlen, input logic [15:0] vg,
                          input logic [15:0] el);
    pending_words.push_back({1'b1, dlen, vg, el});
  endtask

  task automatic add_ticks(input int n);
    repeat (n) pending_words.push_back({1'b0, 20'($urandom), 16'($urandom), 16'($urandom)});
  endtask

  // one phase: a setting, a handful of notes each followed by ticks
  task automatic run_phase(input logic [15:0] damp, input logic [15:0] dec,
                           input logic [15:0] str, input logic [15:0] br,
                           input logic [1:0] kind, input int idle_s, input int idle_r);
    int n;
    write_reg(CFG_DAMPING, damp);
    write_reg(CFG_DECAY, dec);
    write_reg(CFG_STRETCH, str);
    write_reg(CFG_BRIGHTNESS, br);
    write_reg(CFG_EXC_TYPE, kind);
    send_idle_pct = idle_s;
    stall_pct = idle_r;
    n = 0;
    while (n < 80) begin
      // mostly short periods and bursts so notes ring within the run
      if ($urandom_range(9) == 0)
        add_note(20'($urandom), 16'($urandom), 16'($urandom_range(40)));
      else
        add_note(20'($urandom_range(256 * 40, 256)), 16'($urandom),
                 16'($urandom_range(30)));
      add_ticks($urandom_range(30, 5));
      n += 20;
    end
    drain_words();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_op = 0;
    in_delay_length = 0;
    in_velocity_gain = 0;
    in_excite_length = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = CFG_DAMPING;
    cfg_data = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    idle_cycles = 0;
    checked = 0;
    m_damping = 16'd32768;
    m_decay = 16'd32768;
    m_stretch = 0;
    m_bright = 16'd32768;
    m_exc = EXC_NOISE;
    foreach (m_line[i]) m_line[i] = '0;
    m_widx = 0;
    m_period = 0;
    m_bpos = 0;
    m_blen = 0;
    m_vgain = 0;
    m_lp = 0;
    m_ap = 0;
    m_noise = 32'd54321;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tick before any note, zero burst length, field extremes
    add_ticks(2);
    add_note(20'd0, 16'hFFFF, 16'd0);
    add_ticks(3);
    add_note(20'hFFFFF, 16'hFFFF, 16'd3);
    add_ticks(4);
    add_note(20'd1000, 16'd0, 16'hFFFF);
    add_ticks(2);
    add_note(20'd256, 16'hFFFF, 16'd5);
    add_ticks(7);
    drain_words();
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, EXC_SAW, 0, 0);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, EXC_SINE, 0, 0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              EXC_SAW, 0, 0);
    run_phase(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, EXC_BRIGHT, 51, 0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              EXC_NOISE, 0, 51);
    run_phase(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, EXC_BRIGHT, 6, 6);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              EXC_SINE, 51, 51);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              EXC_NOISE, 0, 0);

    $display("covered %0d sample words over all exciter kinds, register extremes", checked);
    $display("and sender/receiver idling phases; %0d mismatches", mismatches);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/psv_pkg.sv
hw/rtl/psv_div.sv
hw/rtl/psv_ctrl.sv
hw/rtl/psv_dpath.sv
hw/rtl/plucked_string_voice_unit.sv
bench/testbench.sv
